@@ rtl/core/ps2mct_pkg.sv @@
// Shared types, widths and codes for the PS/2 mouse cursor tracker.
`default_nettype none

package ps2mct_pkg;

    // cursor coordinate width
    localparam int COORD_BITS  = 12;
    localparam int COORD_LIMIT = 1 << COORD_BITS;

    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 13;
    // signed sum of a coordinate and a 9-bit delta
    localparam int VAL_W   = COORD_BITS + 2;
    // width that holds both a screen size and the coordinate limit
    localparam int LIM_W   = (CFG_W > COORD_BITS + 1) ? CFG_W : COORD_BITS + 1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_W       = 2 * COORD_BITS + 3;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(768);

    // flags byte bit positions
    localparam int FLAG_LEFT   = 0;
    localparam int FLAG_RIGHT  = 1;
    localparam int FLAG_MOTION = 3;
    localparam int FLAG_XSIGN  = 4;
    localparam int FLAG_YSIGN  = 5;

    // register index (paddr[2])
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    // byte slot within a mouse packet
    typedef enum logic [2:0] {
        POS_FLAGS  = 3'b001,
        POS_XDELTA = 3'b010,
        POS_YDELTA = 3'b100
    } t_pkt_pos;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } t_cfg;

    // completed packet handed from the framer to the update stage
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] flags;
        logic [BYTE_W-1:0] x_delta;
        logic [BYTE_W-1:0] y_delta;
    } t_pkt;

endpackage

`default_nettype wire

@@ rtl/core/ps2mct_cfg.sv @@
// APB register file holding the screen size.
`default_nettype none

module ps2mct_cfg (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [ps2mct_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [ps2mct_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ps2mct_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                  pready,
    output ps2mct_pkg::t_cfg                      o_cfg
);

    ps2mct_pkg::t_cfg r_cfg;
    logic             wr_en;
    logic             sel_height;

    assign pready     = 1'b1;
    assign wr_en      = psel && penable && pwrite;
    assign sel_height = (paddr[2] == ps2mct_pkg::REG_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= ps2mct_pkg::WIDTH_RESET;
            r_cfg.height <= ps2mct_pkg::HEIGHT_RESET;
        end else if (wr_en) begin
            if (sel_height) begin
                r_cfg.height <= pwdata[ps2mct_pkg::CFG_W-1:0];
            end else begin
                r_cfg.width <= pwdata[ps2mct_pkg::CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (sel_height) begin
            prdata = ps2mct_pkg::APB_DATA_W'(r_cfg.height);
        end else begin
            prdata = ps2mct_pkg::APB_DATA_W'(r_cfg.width);
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/core/ps2mct_framer.sv @@
// Input beat register and three-byte mouse packet framing.
`default_nettype none

module ps2mct_framer (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_tvalid,
    output logic                                o_tready,
    input  wire  [ps2mct_pkg::BYTE_W-1:0]       i_byte,
    input  wire                                 i_aux,
    input  wire                                 i_out_free,
    output ps2mct_pkg::t_pkt                    o_pkt
);

    logic                           r_in_valid;
    logic [ps2mct_pkg::BYTE_W-1:0]  r_in_byte;
    logic                           r_in_aux;

    ps2mct_pkg::t_pkt_pos           r_pos, n_pos;
    logic [ps2mct_pkg::BYTE_W-1:0]  r_flags, n_flags;
    logic [ps2mct_pkg::BYTE_W-1:0]  r_xd, n_xd;

    logic completes;
    logic advance;

    // a packet-closing byte waits only when the result slot is busy
    assign completes = r_in_aux && (r_pos == ps2mct_pkg::POS_YDELTA);
    assign advance   = r_in_valid && (!completes || i_out_free);
    assign o_tready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_tready) begin
            r_in_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_in_byte <= i_byte;
            r_in_aux  <= i_aux;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_flags = r_flags;
        n_xd    = r_xd;
        if (advance && r_in_aux) begin
            case (r_pos)
                ps2mct_pkg::POS_XDELTA: begin
                    n_xd  = r_in_byte;
                    n_pos = ps2mct_pkg::POS_YDELTA;
                end
                ps2mct_pkg::POS_YDELTA: begin
                    n_pos = ps2mct_pkg::POS_FLAGS;
                end
                default: begin
                    n_flags = r_in_byte;
                    n_pos   = ps2mct_pkg::POS_XDELTA;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= ps2mct_pkg::POS_FLAGS;
            r_flags <= '0;
            r_xd    <= '0;
        end else begin
            r_pos   <= n_pos;
            r_flags <= n_flags;
            r_xd    <= n_xd;
        end
    end

    assign o_pkt.valid   = advance && completes;
    assign o_pkt.flags   = r_flags;
    assign o_pkt.x_delta = r_xd;
    assign o_pkt.y_delta = r_in_byte;

endmodule

`default_nettype wire

@@ rtl/core/ps2mct_update.sv @@
// Cursor update, clamp and result register.
`default_nettype none

module ps2mct_update (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  ps2mct_pkg::t_pkt                         i_pkt,
    input  ps2mct_pkg::t_cfg                         i_cfg,
    output logic                                     o_out_free,
    output logic                                     o_tvalid,
    input  wire                                      i_tready,
    output logic [ps2mct_pkg::OUT_TDATA_W-1:0]       o_tdata
);

    localparam int CB = ps2mct_pkg::COORD_BITS;
    localparam int VW = ps2mct_pkg::VAL_W;
    localparam int LW = ps2mct_pkg::LIM_W;

    logic [CB-1:0] r_pos_x, r_pos_y;
    logic [CB-1:0] n_pos_x, n_pos_y;
    logic          r_out_valid;
    logic          r_left, r_right, r_motion;

    logic                 apply;
    logic signed [VW-1:0] dx, dy, vx, vy;

    // size 0 counts as 1, sizes above the coordinate range saturate
    function automatic logic [CB-1:0] clamp_coord(
        input logic signed [VW-1:0]            v,
        input logic [ps2mct_pkg::CFG_W-1:0]    size
    );
        logic [LW-1:0] s;
        logic [CB-1:0] top;
        s = LW'(size);
        if (s == '0) begin
            s = LW'(1);
        end
        if (s > LW'(ps2mct_pkg::COORD_LIMIT)) begin
            s = LW'(ps2mct_pkg::COORD_LIMIT);
        end
        top = CB'(s - LW'(1));
        if (v[VW-1]) begin
            clamp_coord = '0;
        end else if (v[VW-2:0] > (VW-1)'(top)) begin
            clamp_coord = top;
        end else begin
            clamp_coord = v[CB-1:0];
        end
    endfunction

    assign apply = i_pkt.flags[ps2mct_pkg::FLAG_MOTION];
    assign dx = VW'($signed({i_pkt.flags[ps2mct_pkg::FLAG_XSIGN], i_pkt.x_delta}));
    assign dy = VW'($signed({i_pkt.flags[ps2mct_pkg::FLAG_YSIGN], i_pkt.y_delta}));

    always_comb begin
        vx = $signed(VW'(r_pos_x));
        vy = $signed(VW'(r_pos_y));
        if (apply) begin
            vx = vx + dx;
            vy = vy - dy;
        end
        n_pos_x = clamp_coord(vx, i_cfg.width);
        n_pos_y = clamp_coord(vy, i_cfg.height);
    end

    assign o_out_free = !r_out_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
        end else if (i_pkt.valid) begin
            r_out_valid <= 1'b1;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt.valid) begin
            r_left   <= i_pkt.flags[ps2mct_pkg::FLAG_LEFT];
            r_right  <= i_pkt.flags[ps2mct_pkg::FLAG_RIGHT];
            r_motion <= apply;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {{(ps2mct_pkg::OUT_TDATA_W - ps2mct_pkg::OUT_W){1'b0}},
                       r_motion, r_right, r_left, r_pos_y, r_pos_x};

endmodule

`default_nettype wire

@@ rtl/core/ps2_mouse_cursor_tracker_top.sv @@
// Top level of the PS/2 mouse cursor tracker.
//
//  channel    dir   handshake                      payload
//  s_axis     in    tvalid/tready                  tdata[7:0] byte, tuser aux-port flag
//  m_axis     out   tvalid/tready                  tdata: x, y, left, right, motion
//  apb        in    psel/penable/pwrite, pready=1  0x0 screen_width, 0x4 screen_height
//
//  One beat per cycle when s_axis does not stall: a beat is held in the input register,
//  then framing and the add/clamp feed the result register, which presents a
//  packet's result on m_axis once its third mouse byte has passed both registers.
//  Reset (synchronous, active low) restores 1024x768, cursor 0,0, framing at flags.
//  Only a packet-closing byte stalls s_axis, and only while a result waits
//  on m_axis; keyboard bytes and the first two packet bytes never stall.
`default_nettype none

module ps2_mouse_cursor_tracker_top (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    // slave stream
    input  wire                                      i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    input  wire  [ps2mct_pkg::IN_TDATA_W-1:0]        i_s_axis_tdata,  // [7:0] data_byte
    input  wire                                      i_s_axis_tuser,  // [0] from_aux_port
    // master stream
    output logic                                     o_m_axis_tvalid,
    input  wire                                      i_m_axis_tready,
    // [11:0] cursor_x, [23:12] cursor_y, [24] left_button, [25] right_button,
    // [26] motion_applied, [31:27] zero
    output logic [ps2mct_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // APB configuration
    input  wire                                      psel,
    input  wire                                      penable,
    input  wire                                      pwrite,
    input  wire  [ps2mct_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire  [ps2mct_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [ps2mct_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                     pready
);

    ps2mct_pkg::t_cfg cfg;
    ps2mct_pkg::t_pkt pkt;
    logic             out_free;

    ps2mct_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // byte register and packet framing
    ps2mct_framer u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tvalid   (i_s_axis_tvalid),
        .o_tready   (o_s_axis_tready),
        .i_byte     (i_s_axis_tdata[ps2mct_pkg::BYTE_W-1:0]),
        .i_aux      (i_s_axis_tuser),
        .i_out_free (out_free),
        .o_pkt      (pkt)
    );

    // add deltas, clamp to the screen, hold the result beat
    ps2mct_update u_update (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (pkt),
        .i_cfg      (cfg),
        .o_out_free (out_free),
        .o_tvalid   (o_m_axis_tvalid),
        .i_tready   (i_m_axis_tready),
        .o_tdata    (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ rtl/core/ps2mct_checker.sv @@
// Port-level checks for the cursor tracker, bound to the top level.
`default_nettype none

module ps2mct_checker (
    input wire                                   i_clk,
    input wire                                   i_rst_n,
    input wire                                   i_s_tready,
    input wire                                   i_m_tvalid,
    input wire                                   i_m_tready,
    input wire [ps2mct_pkg::OUT_TDATA_W-1:0]     i_m_tdata
);

    logic m_fire;
    assign m_fire = i_m_tvalid && i_m_tready;

    // a waiting result beat holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result beat changed while stalled");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_s_tready |-> i_m_tvalid && !i_m_tready)
        else $error("input stalled without output backpressure");

    // every packet needs three bytes, so no third result right after two
    a_packet_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_fire ##1 m_fire |=> !i_m_tvalid)
        else $error("results closer than packet framing allows");

endmodule

bind ps2_mouse_cursor_tracker_top ps2mct_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);

`default_nettype wire
